>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the scheduler modules. Each macro samples on
// clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge out of reset
`define CHK_HOLDS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("scheduler check failed");

// Consequent holds in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`else

`define CHK_HOLDS(lbl, prop)
`define CHK_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/rrtss_pkg.sv
// ----------------------------------------------------------------------------
// rrtss_pkg
// Types, constants and helpers of the round-robin thread slot scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrtss_pkg;

	// Table geometry
	localparam int SLOTS     = 8;
	localparam int ID_BITS   = 16;
	localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Fixed port widths
	localparam int FUNC_BITS   = 2;
	localparam int TID_BITS    = 16;
	localparam int STATUS_BITS = 2;
	localparam int RUN_BITS    = 3;

	// Width of the id lookup compare (both sides zero-extended)
	localparam int CMP_BITS = (ID_BITS > TID_BITS) ? ID_BITS : TID_BITS;

	typedef enum logic [1:0] {
		SL_FREE     = 2'd0,
		SL_RUNNABLE = 2'd1,
		SL_RUNNING  = 2'd2,
		SL_ZOMBIE   = 2'd3
	} slot_st_t;

	typedef enum logic [FUNC_BITS-1:0] {
		FN_CREATE = 2'd0,
		FN_YIELD  = 2'd1,
		FN_FINISH = 2'd2,
		FN_JOIN   = 2'd3
	} func_t;

	typedef enum logic [STATUS_BITS-1:0] {
		RS_OK        = 2'd0,
		RS_NO_SLOT   = 2'd1,
		RS_NOT_FOUND = 2'd2,
		RS_PENDING   = 2'd3
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CRE_SCAN,
		S_JOIN_SCAN,
		S_MARK,
		S_YSETUP,
		S_YSCAN,
		S_YFIX,
		S_YTAKE,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_START,
		DP_STEP,
		DP_YSETUP,
		DP_MARK_ZOMBIE,
		DP_CREATE_HIT,
		DP_FREE_HIT,
		DP_YFIX,
		DP_YTAKE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   set_res;
		res_t   code;
	} dp_cmd_t;

	typedef struct packed {
		logic probe_free;
		logic probe_runnable;
		logic probe_match;
		logic probe_zombie;
		logic scan_last;
	} dp_sts_t;

	// Next slot index, round-robin
	function automatic logic [SLOT_BITS-1:0] wrap_inc(input logic [SLOT_BITS-1:0] i);
		logic [SLOT_BITS-1:0] r;
		if (i == SLOT_BITS'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/rrtss_ctrl.sv
// ----------------------------------------------------------------------------
// rrtss_ctrl
// Request sequencer: walks create, yield, finish and join through the slot
// table one probe per cycle and drives the datapath by command.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrtss_ctrl (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [rrtss_pkg::FUNC_BITS-1:0]      func,
	input  wire rrtss_pkg::dp_sts_t                   sts,
	output rrtss_pkg::dp_cmd_t                        cmd,
	output logic                                      busy,
	output logic                                      done
);

	rrtss_pkg::state_t state_q;
	rrtss_pkg::state_t state_d;
	rrtss_pkg::func_t  req;

	assign req = rrtss_pkg::func_t'(func);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrtss_pkg::S_IDLE: begin
				if (start) begin
					unique case (req)
						rrtss_pkg::FN_CREATE: state_d = rrtss_pkg::S_CRE_SCAN;
						rrtss_pkg::FN_YIELD:  state_d = rrtss_pkg::S_YSETUP;
						rrtss_pkg::FN_FINISH: state_d = rrtss_pkg::S_MARK;
						rrtss_pkg::FN_JOIN:   state_d = rrtss_pkg::S_JOIN_SCAN;
						default:              state_d = rrtss_pkg::S_IDLE;
					endcase
				end
			end
			rrtss_pkg::S_CRE_SCAN: begin
				if (sts.probe_free || sts.scan_last) begin
					state_d = rrtss_pkg::S_DONE;
				end
			end
			rrtss_pkg::S_JOIN_SCAN: begin
				priority if (sts.probe_match && sts.probe_zombie) begin
					state_d = rrtss_pkg::S_DONE;
				end else if (sts.probe_match) begin
					state_d = rrtss_pkg::S_YSETUP;
				end else if (sts.scan_last) begin
					state_d = rrtss_pkg::S_DONE;
				end else begin
					state_d = rrtss_pkg::S_JOIN_SCAN;
				end
			end
			rrtss_pkg::S_MARK:   state_d = rrtss_pkg::S_YSETUP;
			rrtss_pkg::S_YSETUP: state_d = rrtss_pkg::S_YSCAN;
			rrtss_pkg::S_YSCAN: begin
				priority if (sts.probe_runnable) begin
					state_d = rrtss_pkg::S_YFIX;
				end else if (sts.scan_last) begin
					state_d = rrtss_pkg::S_DONE;
				end else begin
					state_d = rrtss_pkg::S_YSCAN;
				end
			end
			rrtss_pkg::S_YFIX:  state_d = rrtss_pkg::S_YTAKE;
			rrtss_pkg::S_YTAKE: state_d = rrtss_pkg::S_DONE;
			rrtss_pkg::S_DONE:  state_d = rrtss_pkg::S_IDLE;
			default:            state_d = rrtss_pkg::S_IDLE;
		endcase
	end

	// Commands and strobes
	always_comb begin
		cmd.op      = rrtss_pkg::DP_NOP;
		cmd.set_res = 1'b0;
		cmd.code    = rrtss_pkg::RS_OK;
		busy        = (state_q != rrtss_pkg::S_IDLE);
		done        = 1'b0;
		unique case (state_q)
			rrtss_pkg::S_IDLE: begin
				if (start) begin
					cmd.op = rrtss_pkg::DP_START;
				end
			end
			rrtss_pkg::S_CRE_SCAN: begin
				priority if (sts.probe_free) begin
					cmd.op = rrtss_pkg::DP_CREATE_HIT;
				end else if (sts.scan_last) begin
					cmd.set_res = 1'b1;
					cmd.code    = rrtss_pkg::RS_NO_SLOT;
				end else begin
					cmd.op = rrtss_pkg::DP_STEP;
				end
			end
			rrtss_pkg::S_JOIN_SCAN: begin
				priority if (sts.probe_match && sts.probe_zombie) begin
					cmd.op = rrtss_pkg::DP_FREE_HIT;
				end else if (sts.probe_match) begin
					cmd.set_res = 1'b1;
					cmd.code    = rrtss_pkg::RS_PENDING;
				end else if (sts.scan_last) begin
					cmd.set_res = 1'b1;
					cmd.code    = rrtss_pkg::RS_NOT_FOUND;
				end else begin
					cmd.op = rrtss_pkg::DP_STEP;
				end
			end
			rrtss_pkg::S_MARK:   cmd.op = rrtss_pkg::DP_MARK_ZOMBIE;
			rrtss_pkg::S_YSETUP: cmd.op = rrtss_pkg::DP_YSETUP;
			rrtss_pkg::S_YSCAN: begin
				if (!sts.probe_runnable && !sts.scan_last) begin
					cmd.op = rrtss_pkg::DP_STEP;
				end
			end
			rrtss_pkg::S_YFIX:  cmd.op = rrtss_pkg::DP_YFIX;
			rrtss_pkg::S_YTAKE: cmd.op = rrtss_pkg::DP_YTAKE;
			rrtss_pkg::S_DONE:  done = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrtss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CHK_NEXT(a_accept_goes_busy, start && !busy, busy)
	`CHK_NEXT(a_done_returns_idle, done, !busy && !done)
	`CHK_HOLDS(a_done_only_busy, !done || busy)

endmodule

`default_nettype wire

>>> sv/rrtss_dp.sv
// ----------------------------------------------------------------------------
// rrtss_dp
// Scheduler datapath: slot status and id table, current slot, id counter,
// scan pointer and result registers, driven by sequencer commands.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrtss_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire rrtss_pkg::dp_cmd_t                   cmd,
	input  wire logic [rrtss_pkg::TID_BITS-1:0]       tid,
	output rrtss_pkg::dp_sts_t                        sts,
	output logic [rrtss_pkg::STATUS_BITS-1:0]         status,
	output logic [rrtss_pkg::TID_BITS-1:0]            new_tid,
	output logic [rrtss_pkg::RUN_BITS-1:0]            running_slot,
	output logic                                      switched
);

	rrtss_pkg::slot_st_t                 status_q [rrtss_pkg::SLOTS];
	logic [rrtss_pkg::ID_BITS-1:0]       id_q     [rrtss_pkg::SLOTS];
	logic [rrtss_pkg::SLOT_BITS-1:0]     cur_q;
	logic [rrtss_pkg::SLOT_BITS-1:0]     start_cur_q;
	logic [rrtss_pkg::SLOT_BITS-1:0]     ptr_q;
	logic [rrtss_pkg::SLOT_BITS-1:0]     cnt_q;
	logic [rrtss_pkg::ID_BITS-1:0]       next_id_q;
	logic [rrtss_pkg::TID_BITS-1:0]      tid_q;
	logic                                was_run_q;
	rrtss_pkg::res_t                     res_q;
	logic [rrtss_pkg::TID_BITS-1:0]      new_tid_q;

	logic [rrtss_pkg::SLOT_BITS-1:0]     rd_idx;
	rrtss_pkg::slot_st_t                 rd_st;
	logic [rrtss_pkg::ID_BITS-1:0]       rd_id;
	logic [rrtss_pkg::SLOTS-1:0]         run_vec;

	// Probe the table at the scan pointer
	assign rd_idx = ptr_q;
	assign rd_st  = status_q[rd_idx];
	assign rd_id  = id_q[rd_idx];

	// Probe status for the sequencer
	always_comb begin
		sts.probe_free     = (rd_st == rrtss_pkg::SL_FREE);
		sts.probe_runnable = (rd_st == rrtss_pkg::SL_RUNNABLE);
		sts.probe_zombie   = (rd_st == rrtss_pkg::SL_ZOMBIE);
		sts.probe_match    = (rd_st != rrtss_pkg::SL_FREE) &&
			(rrtss_pkg::CMP_BITS'(rd_id) == rrtss_pkg::CMP_BITS'(tid_q));
		sts.scan_last      = (cnt_q == rrtss_pkg::SLOT_BITS'(rrtss_pkg::SLOTS - 1));
	end

	// Running flags, one per slot
	always_comb begin
		for (int i = 0; i < rrtss_pkg::SLOTS; i++) begin
			run_vec[i] = (status_q[i] == rrtss_pkg::SL_RUNNING);
		end
	end

	// Result ports
	assign status       = res_q;
	assign new_tid      = new_tid_q;
	assign running_slot = rrtss_pkg::RUN_BITS'(cur_q);
	assign switched     = (cur_q != start_cur_q);

	// Table, counters and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rrtss_pkg::SLOTS; i++) begin
				status_q[i] <= rrtss_pkg::SL_FREE;
				id_q[i]     <= '0;
			end
			cur_q       <= '0;
			start_cur_q <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			next_id_q   <= rrtss_pkg::ID_BITS'(1);
			tid_q       <= '0;
			was_run_q   <= 1'b0;
			res_q       <= rrtss_pkg::RS_OK;
			new_tid_q   <= '0;
		end else begin
			if (cmd.set_res) begin
				res_q <= cmd.code;
			end
			unique case (cmd.op)
				rrtss_pkg::DP_NOP: begin
				end
				rrtss_pkg::DP_START: begin
					tid_q       <= tid;
					start_cur_q <= cur_q;
					res_q       <= rrtss_pkg::RS_OK;
					new_tid_q   <= '0;
					ptr_q       <= '0;
					cnt_q       <= '0;
				end
				rrtss_pkg::DP_STEP: begin
					ptr_q <= rrtss_pkg::wrap_inc(ptr_q);
					cnt_q <= cnt_q + 1'b1;
				end
				rrtss_pkg::DP_YSETUP: begin
					ptr_q     <= rrtss_pkg::wrap_inc(cur_q);
					cnt_q     <= '0;
					was_run_q <= (status_q[cur_q] == rrtss_pkg::SL_RUNNING);
				end
				rrtss_pkg::DP_MARK_ZOMBIE: begin
					status_q[cur_q] <= rrtss_pkg::SL_ZOMBIE;
				end
				rrtss_pkg::DP_CREATE_HIT: begin
					status_q[ptr_q] <= rrtss_pkg::SL_RUNNABLE;
					id_q[ptr_q]     <= next_id_q;
					new_tid_q       <= rrtss_pkg::TID_BITS'(next_id_q);
					// wrap from all ones back to one
					if (next_id_q == {rrtss_pkg::ID_BITS{1'b1}}) begin
						next_id_q <= rrtss_pkg::ID_BITS'(1);
					end else begin
						next_id_q <= next_id_q + 1'b1;
					end
				end
				rrtss_pkg::DP_FREE_HIT: begin
					status_q[ptr_q] <= rrtss_pkg::SL_FREE;
					id_q[ptr_q]     <= '0;
				end
				rrtss_pkg::DP_YFIX: begin
					if (was_run_q) begin
						status_q[cur_q] <= rrtss_pkg::SL_RUNNABLE;
					end
				end
				rrtss_pkg::DP_YTAKE: begin
					status_q[ptr_q] <= rrtss_pkg::SL_RUNNING;
					cur_q           <= ptr_q;
				end
				default: begin
				end
			endcase
		end
	end

	`CHK_HOLDS(a_next_id_nonzero, next_id_q != '0)
	`CHK_HOLDS(a_one_running, $countones(run_vec) <= 1)
	`CHK_NEXT(a_take_runs, cmd.op == rrtss_pkg::DP_YTAKE,
		status_q[cur_q] == rrtss_pkg::SL_RUNNING)

endmodule

`default_nettype wire

>>> sv/round_robin_thread_slot_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_thread_slot_scheduler_unit
// Thread slot table with create, round-robin yield, finish and join requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result, which appears for one cycle with done high and must be
// captured then, as the block cannot be held off. The sequencer probes one
// slot per cycle at the scan pointer, so the time from the accepting edge to
// the edge that ends the done cycle depends on the request and on where the
// scan stops. Create scans for a free slot and then ends; yield sets up the
// scan, scans for a runnable slot and on a hit makes the old running slot
// runnable and runs the new one, or on a miss ends; finish marks the current
// slot zombie and then yields; join ends on a zombie or a missing id, and on
// a live match sets pending and yields. Busy is low again the cycle after done.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_slot_scheduler_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [rrtss_pkg::FUNC_BITS-1:0]      func,
	input  wire logic [rrtss_pkg::TID_BITS-1:0]       tid,
	output logic                                      busy,
	output logic                                      done,
	output logic [rrtss_pkg::STATUS_BITS-1:0]         status,
	output logic [rrtss_pkg::TID_BITS-1:0]            new_tid,
	output logic [rrtss_pkg::RUN_BITS-1:0]            running_slot,
	output logic                                      switched
);

	rrtss_pkg::dp_cmd_t cmd;
	rrtss_pkg::dp_sts_t sts;

	// Sequencer
	rrtss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Slot table and result registers
	rrtss_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.tid          (tid),
		.sts          (sts),
		.status       (status),
		.new_tid      (new_tid),
		.running_slot (running_slot),
		.switched     (switched)
	);

endmodule

`default_nettype wire
